// ===== rtl/bba_pkg.sv =====
// Shared types, codes and defaults for the block bitmap allocator.
`default_nettype none

package bba_pkg;

   localparam int MAX_BLOCKS_DEF    = 65536;
   localparam int MAP_WORD_BITS_DEF = 64;

   localparam int CFG_W     = 17;
   localparam int CMD_W     = 2;
   localparam int BLK_W     = 16;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_FORMAT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED = 1'd1;

   localparam logic [CFG_W-1:0] TOTAL_RESET    = 17'd65536;
   localparam logic [CFG_W-1:0] RESERVED_RESET = 17'd0;
   localparam logic [CFG_W-1:0] FREE_RESET     = 17'd65536;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [BLK_W-1:0] block_number;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BLK_W-1:0]    result_block;
      logic                bit_value;
      logic [CFG_W-1:0]    free_count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/block_bitmap_allocator.sv =====
// Top level of the first-fit block bitmap allocator with its map memory and sequencer.
// Format writes every map word; allocate reads map words from the first until one holds
// a free bit (one word per cycle through the map read port); free and query read and
// modify one addressed word; a zero-count allocate and an out-of-range block are answered at decode.
// Throughput: one command at a time; the next is taken on return to idle.
// Reset: synchronous; a clearing pass writes all MAP_WORDS map words, one per cycle,
// with no command taken; configuration writes are taken throughout.
`default_nettype none

module block_bitmap_allocator #(
   parameter int MAX_BLOCKS    = bba_pkg::MAX_BLOCKS_DEF,
   parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // command channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire bba_pkg::req_type               req_data,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output bba_pkg::rsp_type                    rsp_data,
   // configuration write channel
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bba_pkg::CFG_W-1:0]      csr_data
);

   localparam int W         = MAP_WORD_BITS;
   localparam int MAP_WORDS = (MAX_BLOCKS + W - 1) / W;
   localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int OFF_W     = $clog2(W);
   localparam int BASE_W    = $clog2(MAP_WORDS * W + 1);
   // wide enough for every block position, the cap and the count plus one
   localparam int CMP_W     = (BASE_W > bba_pkg::CFG_W + 1) ? BASE_W : bba_pkg::CFG_W + 1;
   localparam int LAST_WORD = MAP_WORDS - 1;
   // word index of a block number by reciprocal multiply, exact for 16-bit dividends
   localparam int RECIP_S   = bba_pkg::BLK_W + $clog2(W);
   localparam int RECIP_W   = bba_pkg::BLK_W + 2;
   localparam int RECIP     = ((2 ** RECIP_S) + W - 1) / W;
   localparam int PROD_W    = bba_pkg::BLK_W + RECIP_W;

   localparam logic [2:0] ST_CLR    = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DECODE = 3'd2;
   localparam logic [2:0] ST_FMT    = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;
   localparam logic [2:0] ST_ADDR   = 3'd5;
   localparam logic [2:0] ST_MOD    = 3'd6;

   // control state
   logic [2:0]                 state_ff, state_in;
   logic [WA_W-1:0]            w_ff, w_in;
   logic [bba_pkg::CFG_W-1:0]  free_ff, free_in;
   logic [bba_pkg::CFG_W-1:0]  total_ff, total_in;
   logic [bba_pkg::CFG_W-1:0]  reserved_ff, reserved_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // payload state
   bba_pkg::req_type           req_ff, req_in;
   bba_pkg::rsp_type           rsp_ff, rsp_in;
   logic [CMP_W-1:0]           base_ff, base_in;
   logic [CMP_W-1:0]           lim_ff, lim_in;
   logic [OFF_W-1:0]           off_ff, off_in;

   // map memory: one bit per block, MAP_WORDS words
   logic [W-1:0]               map_mem [MAP_WORDS];
   logic [W-1:0]               rd_data_ff;
   logic                       mem_we, mem_re;
   logic [WA_W-1:0]            mem_waddr, mem_raddr;
   logic [W-1:0]               mem_wdata;

   logic                       slot_free;
   logic                       rsp_load;
   bba_pkg::rsp_type           rsp_new;
   logic [CMP_W-1:0]           size_c;
   logic [CMP_W-1:0]           total_x;
   logic [CMP_W-1:0]           reserved_x;
   logic [CMP_W-1:0]           bn_x;
   logic [CMP_W-1:0]           lim_sel;
   logic [CMP_W-1:0]           rem_c;
   logic                       lim_gt;
   logic [W-1:0]               thermo;
   logic                       ff_found;
   logic [OFF_W-1:0]           ff_index;
   logic [PROD_W-1:0]          quot_prod;
   logic [CMP_W-1:0]           alloc_blk;
   logic [CMP_W-1:0]           bit_pos;
   logic [CMP_W-1:0]           inc_free;
   logic [CMP_W-1:0]           fmt_rsv;

   assign total_x    = CMP_W'(total_ff);
   assign reserved_x = CMP_W'(reserved_ff);
   assign bn_x       = CMP_W'(req_ff.block_number);

   // managed size: total capped at the map capacity
   assign size_c = (total_x > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : total_x;

   assign fmt_rsv   = (reserved_x > size_c) ? size_c : reserved_x;
   assign quot_prod = PROD_W'(req_ff.block_number) * PROD_W'(RECIP);
   assign alloc_blk = base_ff + CMP_W'(ff_index);
   assign bit_pos   = bn_x - (CMP_W'(w_ff) * CMP_W'(W));
   assign inc_free  = CMP_W'(free_ff) + CMP_W'(1);

   // thermometer of bits below a limit within the current word: the reserved
   // prefix while formatting, the in-range bits while scanning
   assign lim_sel = (state_ff == ST_FMT) ? lim_ff : size_c;
   assign lim_gt  = lim_sel > base_ff;
   assign rem_c   = lim_sel - base_ff;

   always_comb begin
      for (int i = 0; i < W; i++) begin
         thermo[i] = lim_gt && (rem_c > CMP_W'(i));
      end
   end

   bba_first_free #(
      .WORD_BITS (W)
   ) u_first_free (
      .word       (rd_data_ff),
      .valid_mask (thermo),
      .found      (ff_found),
      .index      (ff_index)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // configuration registers
   always_comb begin
      total_in    = total_ff;
      reserved_in = reserved_ff;
      if (csr_valid) begin
         case (csr_index)
            bba_pkg::CSR_TOTAL:    total_in    = csr_data;
            bba_pkg::CSR_RESERVED: reserved_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      w_in      = w_ff;
      free_in   = free_ff;
      req_in    = req_ff;
      base_in   = base_ff;
      lim_in    = lim_ff;
      off_in    = off_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = w_ff;
      mem_raddr = w_ff;
      mem_wdata = '0;
      rsp_load  = 1'b0;
      rsp_new   = '0;

      case (state_ff)
         ST_CLR: begin
            // clear one word per cycle after reset
            mem_we = 1'b1;
            w_in   = w_ff + WA_W'(1);
            if (w_ff == WA_W'(LAST_WORD)) begin
               w_in     = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            case (req_ff.cmd)
               bba_pkg::CMD_FORMAT: begin
                  lim_in   = fmt_rsv;
                  free_in  = bba_pkg::CFG_W'(size_c - fmt_rsv);
                  w_in     = '0;
                  base_in  = '0;
                  state_in = ST_FMT;
               end
               bba_pkg::CMD_ALLOC: begin
                  if (free_ff == '0) begin
                     // count zero: answer full, touch nothing
                     if (slot_free) begin
                        rsp_load           = 1'b1;
                        rsp_new.status     = bba_pkg::STATUS_FULL;
                        rsp_new.free_count = free_ff;
                        state_in           = ST_IDLE;
                     end
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = '0;
                     w_in      = '0;
                     base_in   = '0;
                     state_in  = ST_SCAN;
                  end
               end
               default: begin
                  // free and query share the range check and address step
                  if (bn_x >= size_c) begin
                     if (slot_free) begin
                        rsp_load             = 1'b1;
                        rsp_new.status       = bba_pkg::STATUS_RANGE;
                        rsp_new.result_block = req_ff.block_number;
                        rsp_new.free_count   = free_ff;
                        state_in             = ST_IDLE;
                     end
                  end else begin
                     w_in     = WA_W'(quot_prod >> RECIP_S);
                     state_in = ST_ADDR;
                  end
               end
            endcase
         end

         ST_FMT: begin
            // write each word with its share of the reserved prefix
            mem_we    = 1'b1;
            mem_wdata = thermo;
            if (w_ff == WA_W'(LAST_WORD)) begin
               if (slot_free) begin
                  rsp_load           = 1'b1;
                  rsp_new.status     = bba_pkg::STATUS_OK;
                  rsp_new.free_count = free_ff;
                  state_in           = ST_IDLE;
               end
            end else begin
               w_in    = w_ff + WA_W'(1);
               base_in = base_ff + CMP_W'(W);
            end
         end

         ST_SCAN: begin
            if (base_ff >= size_c) begin
               // no clear bit below the size
               if (slot_free) begin
                  rsp_load           = 1'b1;
                  rsp_new.status     = bba_pkg::STATUS_FULL;
                  rsp_new.free_count = free_ff;
                  state_in           = ST_IDLE;
               end
            end else if (ff_found) begin
               if (slot_free) begin
                  mem_we               = 1'b1;
                  mem_wdata            = rd_data_ff | (W'(1) << ff_index);
                  free_in              = free_ff - bba_pkg::CFG_W'(1);
                  rsp_load             = 1'b1;
                  rsp_new.status       = bba_pkg::STATUS_OK;
                  rsp_new.result_block = alloc_blk[bba_pkg::BLK_W-1:0];
                  rsp_new.bit_value    = 1'b1;
                  rsp_new.free_count   = free_ff - bba_pkg::CFG_W'(1);
                  state_in             = ST_IDLE;
               end
            end else begin
               // stream the next word
               mem_re    = (w_ff != WA_W'(LAST_WORD));
               mem_raddr = w_ff + WA_W'(1);
               w_in      = w_ff + WA_W'(1);
               base_in   = base_ff + CMP_W'(W);
            end
         end

         ST_ADDR: begin
            off_in   = bit_pos[OFF_W-1:0];
            mem_re   = 1'b1;
            state_in = ST_MOD;
         end

         ST_MOD: begin
            if (slot_free) begin
               rsp_load             = 1'b1;
               rsp_new.status       = bba_pkg::STATUS_OK;
               rsp_new.result_block = req_ff.block_number;
               state_in             = ST_IDLE;
               if (req_ff.cmd == bba_pkg::CMD_FREE) begin
                  // double free still raises the count, capped at the size
                  mem_we             = 1'b1;
                  mem_wdata          = rd_data_ff & ~(W'(1) << off_ff);
                  free_in            = bba_pkg::CFG_W'((inc_free > size_c) ? size_c : inc_free);
                  rsp_new.free_count = bba_pkg::CFG_W'((inc_free > size_c) ? size_c : inc_free);
               end else begin
                  rsp_new.bit_value  = rd_data_ff[off_ff];
                  rsp_new.free_count = free_ff;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: drop the beat when taken, load a new one when offered
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         w_ff         <= '0;
         free_ff      <= bba_pkg::FREE_RESET;
         total_ff     <= bba_pkg::TOTAL_RESET;
         reserved_ff  <= bba_pkg::RESERVED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         free_ff      <= free_in;
         total_ff     <= total_in;
         reserved_ff  <= reserved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      base_ff <= base_in;
      lim_ff  <= lim_in;
      off_ff  <= off_in;
   end

   // map memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= map_mem[mem_raddr];
      end
   end

   // an allocate that marks a bit hands out a successful beat next cycle
   a_alloc_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && mem_we) |=>
         (rsp_valid_ff && rsp_ff.status == bba_pkg::STATUS_OK && rsp_ff.bit_value))
      else $error("allocate write without a matching result");

   // no map write while waiting on, decoding or addressing a command
   a_no_stray_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_DECODE || state_ff == ST_ADDR) |-> !mem_we)
      else $error("map written outside a modify step");

   // a new result appears only as the sequencer returns to idle
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (state_ff == ST_IDLE))
      else $error("result raised while a command is still at work");

   // the clearing pass neither takes commands nor offers results
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLR) |-> (!req_ready && !rsp_valid_ff))
      else $error("activity during the clearing pass");

   // a stalled free or query holds its modify step
   a_mod_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_MOD))
      else $error("modify step left while the output was blocked");

endmodule

`default_nettype wire

// ===== rtl/bba_first_free.sv =====
// Lowest clear bit finder over one occupancy map word.
`default_nettype none

module bba_first_free #(
   parameter int WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF,
   localparam int IDX_W = $clog2(WORD_BITS)
) (
   input  wire logic [WORD_BITS-1:0] word,
   input  wire logic [WORD_BITS-1:0] valid_mask,
   output logic                      found,
   output logic [IDX_W-1:0]          index
);

   logic [WORD_BITS-1:0] cand;
   logic [WORD_BITS-1:0] low;

   // isolate the lowest clear, in-range bit
   assign cand  = ~word & valid_mask;
   assign low   = cand & (~cand + {{(WORD_BITS-1){1'b0}}, 1'b1});
   assign found = |cand;

   // encode the one-hot position
   always_comb begin
      index = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (low[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the first-fit block bitmap allocator.
`timescale 1ns / 100ps

module testbench;

   // Map geometry of the instance under test; the predictor mirrors it word for word.
   localparam int WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF;
   localparam int MAP_WORDS = bba_pkg::MAX_BLOCKS_DEF / WORD_BITS;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_ready;
   bba_pkg::req_type              req_data    = '0;
   logic                          rsp_valid;
   logic                          rsp_ready   = 1'b0;
   bba_pkg::rsp_type              rsp_data;
   logic                          csr_valid   = 1'b0;
   logic                          csr_ready;
   logic [bba_pkg::CSR_IDX_W-1:0] csr_index   = '0;
   logic [bba_pkg::CFG_W-1:0]     csr_data    = '0;

   // Predictor copy of the allocator: configuration, occupancy map and free counter.
   logic [bba_pkg::CFG_W-1:0]    cfg_total;
   logic [bba_pkg::CFG_W-1:0]    cfg_reserved;
   logic [bba_pkg::CFG_W-1:0]    free_cnt;
   bit [WORD_BITS-1:0]           map_word [MAP_WORDS];

   // Answers still owed by the block, oldest first.
   bba_pkg::rsp_type pending_answers [$];

   int  fail_count    = 0;
   bit  sender_steady = 1'b0;   // when set, the command side offers beats back to back
   int  result_hold   = 0;      // cycles the result side must still refuse beats
   int  stall_left    = 0;
   int  steady_left   = 0;

   block_bitmap_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Blocks actually managed: the configured total, capped at the map size.
   function automatic int managed_size();
      return (cfg_total > bba_pkg::MAX_BLOCKS_DEF) ? bba_pkg::MAX_BLOCKS_DEF
                                                   : int'(cfg_total);
   endfunction

   // Lowest clear bit below lim, or lim when there is none; skip full words whole.
   function automatic int first_clear(int lim);
      int b;
      b = 0;
      while (b < lim) begin
         if ((b % WORD_BITS) == 0 && map_word[b / WORD_BITS] == '1) begin
            b += WORD_BITS;
            continue;
         end
         if (!map_word[b / WORD_BITS][b % WORD_BITS])
            return b;
         b++;
      end
      return lim;
   endfunction

   function automatic void clear_allocator();
      int i;
      for (i = 0; i < MAP_WORDS; i++)
         map_word[i] = '0;
      free_cnt     = bba_pkg::FREE_RESET;
      cfg_total    = bba_pkg::TOTAL_RESET;
      cfg_reserved = bba_pkg::RESERVED_RESET;
   endfunction

   // Apply one command to the predictor state and return the answer it owes.
   function automatic bba_pkg::rsp_type predict_answer(bba_pkg::req_type cmd_beat);
      bba_pkg::rsp_type ans;
      int      size;
      int      rsv;
      int      b;
      int      i;
      int      bumped;
      ans  = '0;
      size = managed_size();
      case (cmd_beat.cmd)
         bba_pkg::CMD_FORMAT: begin
            // A reserve larger than the map marks every block, so the count lands on zero.
            rsv = (cfg_reserved > size) ? size : int'(cfg_reserved);
            for (i = 0; i < MAP_WORDS; i++)
               map_word[i] = '0;
            for (i = 0; i < rsv; i++)
               map_word[i / WORD_BITS][i % WORD_BITS] = 1'b1;
            free_cnt = bba_pkg::CFG_W'(size - rsv);
         end
         bba_pkg::CMD_ALLOC: begin
            // A nonzero count with no clear bit left is still reported as full.
            b = (free_cnt != 0) ? first_clear(size) : size;
            if (b >= size) begin
               ans.status = bba_pkg::STATUS_FULL;
            end else begin
               map_word[b / WORD_BITS][b % WORD_BITS] = 1'b1;
               free_cnt         = free_cnt - 1'b1;
               ans.result_block = bba_pkg::BLK_W'(b);
               ans.bit_value    = 1'b1;
            end
         end
         default: begin
            ans.result_block = cmd_beat.block_number;
            if (cmd_beat.block_number >= size) begin
               ans.status = bba_pkg::STATUS_RANGE;
            end else if (cmd_beat.cmd == bba_pkg::CMD_FREE) begin
               // A double free still bumps the count, capped at the map size.
               bumped = int'(free_cnt) + 1;
               map_word[cmd_beat.block_number / WORD_BITS]
                       [cmd_beat.block_number % WORD_BITS] = 1'b0;
               free_cnt = bba_pkg::CFG_W'((bumped > size) ? size : bumped);
            end else begin
               ans.bit_value = map_word[cmd_beat.block_number / WORD_BITS]
                                       [cmd_beat.block_number % WORD_BITS];
            end
         end
      endcase
      ans.free_count = free_cnt;
      return ans;
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: ready pattern and checking
   // ---------------------------------------------------------------------------

   // Mostly short gaps, now and then a long one.
   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return $urandom_range(1, 2);
      else if (roll < 95)
         return $urandom_range(3, 8);
      return $urandom_range(15, 50);
   endfunction

   // Drive ready at the falling edge. A requested hold-off wins over everything,
   // then steady stretches, then random stalls.
   always @(negedge clock) begin : drive_rsp_ready
      int roll;
      if (result_hold > 0) begin
         rsp_ready   = 1'b0;
         result_hold = result_hold - 1;
      end else if (steady_left > 0) begin
         rsp_ready   = 1'b1;
         steady_left = steady_left - 1;
      end else if (stall_left > 0) begin
         rsp_ready  = 1'b0;
         stall_left = stall_left - 1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            rsp_ready   = 1'b1;
            steady_left = $urandom_range(20, 120);
         end else if (roll < 30) begin
            rsp_ready  = 1'b0;
            stall_left = random_gap() - 1;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Compare every accepted result beat against the oldest owed answer.
   always @(posedge clock) begin : check_answers
      bba_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $error("result beat with no command outstanding: %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.result_block !== want.result_block) begin
               $error("result_block: expected %0d, got %0d",
                      want.result_block, rsp_data.result_block);
               fail_count++;
            end
            if (rsp_data.bit_value !== want.bit_value) begin
               $error("bit_value: expected %0d, got %0d", want.bit_value, rsp_data.bit_value);
               fail_count++;
            end
            if (rsp_data.free_count !== want.free_count) begin
               $error("free_count: expected %0d, got %0d",
                      want.free_count, rsp_data.free_count);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Command and configuration drivers (entered and left at a falling edge)
   // ---------------------------------------------------------------------------

   // Offer one command beat; hold it until accepted, then predict its answer.
   // Valid is left high: the next call either replaces the payload or drops it.
   task automatic issue_cmd(logic [bba_pkg::CMD_W-1:0] op, logic [bba_pkg::BLK_W-1:0] blk);
      bba_pkg::req_type cmd_beat;
      int      gap;
      cmd_beat.cmd          = op;
      cmd_beat.block_number = blk;
      gap = (sender_steady || $urandom_range(0, 1) == 0) ? 0 : random_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = cmd_beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_answers.push_back(predict_answer(cmd_beat));
      @(negedge clock);
   endtask

   // Drop valid and hold the sender until every owed answer has come back.
   task automatic drain_answers();
      req_valid = 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Write one register; only called with the block idle.
   task automatic write_csr(logic [bba_pkg::CSR_IDX_W-1:0] idx,
                            logic [bba_pkg::CFG_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == bba_pkg::CSR_TOTAL)
         cfg_total = value;
      else
         cfg_reserved = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_geometry(logic [bba_pkg::CFG_W-1:0] total,
                               logic [bba_pkg::CFG_W-1:0] reserved);
      drain_answers();
      write_csr(bba_pkg::CSR_TOTAL, total);
      write_csr(bba_pkg::CSR_RESERVED, reserved);
   endtask

   // Random traffic tuned to fill the map: allocates outnumber frees, a few
   // formats restart it, and some block numbers land past the end or anywhere.
   task automatic run_mixed_traffic(int count);
      int                         n;
      int                         roll;
      int                         size;
      int                         past_end;
      logic [bba_pkg::CMD_W-1:0]  op;
      logic [bba_pkg::BLK_W-1:0]  blk;
      sender_steady = ($urandom_range(0, 3) == 0);
      for (n = 0; n < count; n++) begin
         size = managed_size();
         roll = $urandom_range(0, 99);
         if (roll < 3)
            op = bba_pkg::CMD_FORMAT;
         else if (roll < 48)
            op = bba_pkg::CMD_ALLOC;
         else if (roll < 73)
            op = bba_pkg::CMD_FREE;
         else
            op = bba_pkg::CMD_QUERY;
         roll     = $urandom_range(0, 9);
         past_end = size + $urandom_range(0, 2);
         if (roll < 7 && size > 0)
            blk = bba_pkg::BLK_W'($urandom_range(0, size - 1));
         else if (roll == 7 && past_end <= 65535)
            blk = bba_pkg::BLK_W'(past_end);
         else
            blk = bba_pkg::BLK_W'($urandom);
         issue_cmd(op, blk);
      end
      sender_steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Corner cases one by one, starting from the reset configuration.
   task automatic test_directed_cases();
      issue_cmd(bba_pkg::CMD_QUERY, 16'd0);
      issue_cmd(bba_pkg::CMD_QUERY, 16'hFFFF);
      issue_cmd(bba_pkg::CMD_ALLOC, 16'hFFFF);
      issue_cmd(bba_pkg::CMD_ALLOC, 16'd0);
      issue_cmd(bba_pkg::CMD_QUERY, 16'd1);
      // Free the same block three times: the count climbs, then sticks at the size.
      issue_cmd(bba_pkg::CMD_FREE, 16'd0);
      issue_cmd(bba_pkg::CMD_FREE, 16'd0);
      issue_cmd(bba_pkg::CMD_FREE, 16'd0);
      issue_cmd(bba_pkg::CMD_ALLOC, 16'd0);

      // Every block reserved: the count starts at zero.
      set_geometry(17'd10, 17'd10);
      issue_cmd(bba_pkg::CMD_FORMAT, 16'hFFFF);
      issue_cmd(bba_pkg::CMD_ALLOC, 16'd0);
      // Free a reserved block twice, so the count exceeds the clear bits.
      issue_cmd(bba_pkg::CMD_FREE, 16'd3);
      issue_cmd(bba_pkg::CMD_FREE, 16'd3);
      issue_cmd(bba_pkg::CMD_ALLOC, 16'd0);
      issue_cmd(bba_pkg::CMD_ALLOC, 16'd0);
      issue_cmd(bba_pkg::CMD_FREE, 16'd10);
      issue_cmd(bba_pkg::CMD_QUERY, 16'hFFFF);
      issue_cmd(bba_pkg::CMD_QUERY, 16'd9);

      // Empty map: everything is out of range or full.
      set_geometry(17'd0, 17'd65536);
      issue_cmd(bba_pkg::CMD_FORMAT, 16'd0);
      issue_cmd(bba_pkg::CMD_ALLOC, 16'd0);
      issue_cmd(bba_pkg::CMD_QUERY, 16'd0);
      issue_cmd(bba_pkg::CMD_FREE, 16'd0);

      // Reserve far beyond the map size.
      set_geometry(17'd5, 17'h1FFFF);
      issue_cmd(bba_pkg::CMD_FORMAT, 16'd0);
      issue_cmd(bba_pkg::CMD_QUERY, 16'd4);

      // Total beyond the map capacity is capped.
      set_geometry(17'h1FFFF, 17'd0);
      issue_cmd(bba_pkg::CMD_FORMAT, 16'd0);
      issue_cmd(bba_pkg::CMD_QUERY, 16'hFFFF);
      issue_cmd(bba_pkg::CMD_ALLOC, 16'd0);
   endtask

   // Small maps around the word boundary, each formatted and then run with mixed traffic.
   task automatic test_small_maps();
      int totals [7];
      int k;
      int reserved;
      totals = '{1, 63, 64, 65, 128, 0, 0};
      totals[5] = $urandom_range(2, 400);
      totals[6] = $urandom_range(2, 400);
      for (k = 0; k < 7; k++) begin
         case ($urandom_range(0, 9))
            0, 1:    reserved = 0;
            2:       reserved = $urandom_range(totals[k], 131071);
            default: reserved = $urandom_range(0, totals[k]);
         endcase
         set_geometry(bba_pkg::CFG_W'(totals[k]), bba_pkg::CFG_W'(reserved));
         issue_cmd(bba_pkg::CMD_FORMAT, bba_pkg::BLK_W'($urandom));
         run_mixed_traffic(50);
      end
   endtask

   // Resize without formatting, so the count and the map disagree.
   task automatic test_shrink_without_format();
      int k;
      for (k = 0; k < 3; k++) begin
         drain_answers();
         write_csr(bba_pkg::CSR_TOTAL, bba_pkg::CFG_W'($urandom_range(1, 200)));
         run_mixed_traffic(30);
      end
   endtask

   // Full-size map with a modest reserve; block numbers span all 16 bits.
   task automatic test_full_map();
      set_geometry(17'd65536, bba_pkg::CFG_W'($urandom_range(0, 3000)));
      issue_cmd(bba_pkg::CMD_FORMAT, bba_pkg::BLK_W'($urandom));
      run_mixed_traffic(70);
   endtask

   // Hold the result side off while commands keep coming, so the block backs up.
   task automatic test_result_holdoff();
      int n;
      set_geometry(17'd48, 17'd4);
      issue_cmd(bba_pkg::CMD_FORMAT, 16'd0);
      drain_answers();
      @(posedge clock);
      result_hold = 300;
      @(negedge clock);
      sender_steady = 1'b1;
      for (n = 0; n < 30; n++)
         issue_cmd((n % 3 == 2) ? bba_pkg::CMD_QUERY : bba_pkg::CMD_ALLOC,
                   bba_pkg::BLK_W'($urandom_range(0, 63)));
      sender_steady = 1'b0;
      drain_answers();
   endtask

   // Random geometries, including zero, the cap and totals above the cap.
   task automatic test_random_geometry();
      int k;
      int total;
      int reserved;
      for (k = 0; k < 5; k++) begin
         case ($urandom_range(0, 9))
            0:          total = 0;
            1:          total = 65536;
            2:          total = $urandom_range(65537, 131071);
            3, 4, 5, 6: total = $urandom_range(1, 256);
            7, 8:       total = $urandom_range(257, 4096);
            default:    total = $urandom_range(4097, 65535);
         endcase
         reserved = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(0, total / 2);
         set_geometry(bba_pkg::CFG_W'(total), bba_pkg::CFG_W'(reserved));
         issue_cmd(bba_pkg::CMD_FORMAT, bba_pkg::BLK_W'($urandom));
         run_mixed_traffic(20);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------

   initial begin
      clear_allocator();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_small_maps();
      test_shrink_without_format();
      test_full_map();
      test_result_holdoff();
      test_random_geometry();

      // Wait out a full format time after the last answer to catch stray beats.
      drain_answers();
      repeat (MAP_WORDS + 16) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hard limit on the run time.
   initial begin
      #40_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
